/* sv/dbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_pkg: shared constants of the dielectric BSDF sample unit
// Field widths, fixed-point formats, register indexes, reset values and
// event codes.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int DIR_W     = 16;  // direction fields, signed Q1.14
    localparam int IDX_W     = 14;  // refractive indices, unsigned Q2.12
    localparam int U_W       = 16;  // sample, unsigned Q0.16
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam int DIR_FRAC  = 14;
    localparam int IDX_FRAC  = 12;
    localparam int FIX_FRAC  = 30;  // internal cosine / sine formats
    localparam int QUO_W     = FIX_FRAC + 1;

    localparam logic [IDX_W-1:0] RST_INTERIOR = 14'd6163;
    localparam logic [IDX_W-1:0] RST_EXTERIOR = 14'd4097;
    localparam logic [IDX_W-1:0] ETA_MAX      = 14'd16383;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTERIOR = 1'b1;

    localparam logic [KIND_W-1:0] EV_TIR  = 2'd0;
    localparam logic [KIND_W-1:0] EV_REFL = 2'd1;
    localparam logic [KIND_W-1:0] EV_TRAN = 2'd2;

endpackage
`default_nettype wire

/* sv/dbs_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_div: pipelined restoring divider
// One quotient bit per stage, QW stages, all advancing on i_en. The top
// NW-QW bits of the numerator must be below the divisor for a true result.
// ----------------------------------------------------------------------------
module dbs_div #(
    parameter int NW = 31,
    parameter int DW = 14,
    parameter int QW = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int HW = NW - QW;

    logic [DW-1:0] w_rem0;
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_w   [QW];
    logic [DW-1:0] r_den [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_w   [QW];
    logic [DW-1:0] n_den [QW];

    generate
        if (HW == 0) begin : g_rem_zero
            assign w_rem0 = '0;
        end else if (HW < DW) begin : g_rem_ext
            assign w_rem0 = {{(DW-HW){1'b0}}, i_num[NW-1:QW]};
        end else begin : g_rem_cut
            assign w_rem0 = i_num[QW+DW-1:QW];
        end
    endgenerate

    always_comb begin
        logic [DW-1:0] rem;
        logic [QW-1:0] w;
        logic [DW-1:0] den;
        logic [DW:0]   rs;
        logic [DW+1:0] d;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem = w_rem0;
                w   = i_num[QW-1:0];
                den = i_den;
            end else begin
                rem = r_rem[k-1];
                w   = r_w[k-1];
                den = r_den[k-1];
            end
            rs       = {rem, w[QW-1]};
            d        = {1'b0, rs} - {2'b00, den};
            n_rem[k] = d[DW+1] ? rs[DW-1:0] : d[DW-1:0];
            n_w[k]   = {w[QW-2:0], ~d[DW+1]};
            n_den[k] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_w[k]   <= n_w[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_w[QW-1];

endmodule
`default_nettype wire

/* sv/dielectric_bsdf_sample_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dielectric_bsdf_sample_unit: Fresnel-weighted reflect / refract sampler
// Takes a local incident direction and a uniform sample, returns one
// scattered direction, the relative index and the event kind.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid / o_stall with direction x, y, z (Q1.14) and
//   sample u (Q0.16). A beat is taken when i_valid is high and o_stall low.
//   Output channel: o_valid / i_stall with the outgoing direction, eta_ratio
//   (Q2.12) and event_kind; exactly one output beat per input beat, in order.
//   Configuration: i_cfg_we writes i_cfg_wdata to the index register chosen
//   by i_cfg_idx (0 interior, 1 exterior); write only while the pipe is empty.
//   Throughput is one beat per cycle while o_stall is low. The pipe holds
//   three 31-stage digit units in series: the sin^2 divider, the square
//   root for cos(thetaT) and the Fresnel ratio dividers, plus eight
//   arithmetic stages around them.
//   Reset clears every valid bit and loads the default indices (glass and
//   air). When the receiver stalls with a beat waiting, the whole pipe holds
//   and o_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module dielectric_bsdf_sample_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [dbs_pkg::IDX_W-1:0]           i_cfg_wdata,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [dbs_pkg::DIR_W-1:0]    i_in_dir_x,
    input  wire logic signed [dbs_pkg::DIR_W-1:0]    i_in_dir_y,
    input  wire logic signed [dbs_pkg::DIR_W-1:0]    i_in_dir_z,
    input  wire logic [dbs_pkg::U_W-1:0]             i_sample_u,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [dbs_pkg::DIR_W-1:0]         o_out_dir_x,
    output logic signed [dbs_pkg::DIR_W-1:0]         o_out_dir_y,
    output logic signed [dbs_pkg::DIR_W-1:0]         o_out_dir_z,
    output logic [dbs_pkg::IDX_W-1:0]                o_eta_ratio,
    output logic [dbs_pkg::KIND_W-1:0]               o_event_kind
);

    localparam int QN  = dbs_pkg::QUO_W;     // stages of each digit unit
    localparam int LAT = 3 + QN + 1 + QN + 2 + QN + 2;
    localparam int DW  = dbs_pkg::DIR_W;
    localparam int IW  = dbs_pkg::IDX_W;

    localparam logic [DW-1:0]   ONE_DIR = 16'd16384;
    localparam logic [29:0]     ONE_SQ  = 30'd268435456;   // 1.0 squared, Q28
    localparam logic [QN-1:0]   ONE_FX  = 31'h4000_0000;   // 1.0 in Q30

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] z;
        logic [15:0]   u;
        logic          ent;
    } t_item;

    typedef struct packed {
        t_item       it;
        logic        tir;
        logic        eq;
        logic [28:0] a0;
        logic [28:0] p0;
        logic [IW-1:0] ei;
        logic [IW-1:0] et;
    } t_sa;

    typedef struct packed {
        logic          tir;
        logic          eq;
        logic          ent;
        logic [15:0]   u;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [DW-1:0] rz;
        logic [DW-1:0] tx;
        logic [DW-1:0] ty;
        logic [DW-1:0] tz;
        logic [IW-1:0] eta;
    } t_res;

    typedef struct packed {
        t_res        res;
        logic [28:0] a0;
        logic [28:0] p0;
        logic [IW-1:0] ei;
        logic [IW-1:0] et;
    } t_sb;

    typedef struct packed {
        t_res          res;
        logic [QN-1:0] a;
        logic [QN-1:0] b;
        logic [QN-1:0] p;
        logic [QN-1:0] q;
        logic [15:0]   zq;
    } t_sc;

    // negate with saturation of the most negative code
    function automatic logic [DW-1:0] f_neg_sat(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        if (v == 16'h8000) begin
            r = 16'h7FFF;
        end else begin
            r = ~v + 16'd1;
        end
        return r;
    endfunction

    // transmitted lateral component: sign opposite to the input, saturated
    function automatic logic [DW-1:0] f_tx(input logic neg, input logic [QN-1:0] mag);
        logic [DW-1:0] r;
        if (neg) begin
            r = (mag > 31'd32767) ? 16'h7FFF : mag[DW-1:0];
        end else begin
            r = (mag > 31'd32768) ? 16'h8000 : (~mag[DW-1:0] + 16'd1);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- control
    logic           w_adv;
    logic [LAT-1:0] r_vld;
    logic [IW-1:0]  r_int_idx;
    logic [IW-1:0]  r_ext_idx;

    // Advance the whole pipe unless a finished beat is held by the receiver.
    assign w_adv   = ~r_vld[LAT-1] | ~i_stall;
    assign o_stall = ~w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_idx <= dbs_pkg::RST_INTERIOR;
            r_ext_idx <= dbs_pkg::RST_EXTERIOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dbs_pkg::CFG_INTERIOR: r_int_idx <= i_cfg_wdata;
                dbs_pkg::CFG_EXTERIOR: r_ext_idx <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Choose the index order from the sign of z and clamp |z| to 1.0.
    logic          w_ent;
    logic [DW-1:0] w_zabs;
    logic [14:0]   w_zc;
    t_item         r1_it;
    logic [IW-1:0] r1_ei;
    logic [IW-1:0] r1_et;
    logic [14:0]   r1_zc;

    assign w_ent  = ~i_in_dir_z[DW-1] & (i_in_dir_z != '0);
    assign w_zabs = i_in_dir_z[DW-1] ? (~i_in_dir_z + 16'd1) : i_in_dir_z;
    assign w_zc   = (w_zabs > ONE_DIR) ? ONE_DIR[14:0] : w_zabs[14:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_it.x   <= i_in_dir_x;
            r1_it.y   <= i_in_dir_y;
            r1_it.z   <= i_in_dir_z;
            r1_it.u   <= i_sample_u;
            r1_it.ent <= w_ent;
            r1_ei     <= w_ent ? r_ext_idx : r_int_idx;
            r1_et     <= w_ent ? r_int_idx : r_ext_idx;
            r1_zc     <= w_zc;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // sin^2(thetaI) in Q28, index squares and the lateral products.
    logic [29:0]   w_zc2;
    logic [DW-1:0] w_xabs;
    logic [DW-1:0] w_yabs;
    t_item         r2_it;
    logic [28:0]   r2_s;
    logic [27:0]   r2_ei2;
    logic [27:0]   r2_et2;
    logic [29:0]   r2_mx;
    logic [29:0]   r2_my;
    logic [28:0]   r2_a0;
    logic [28:0]   r2_p0;
    logic [26:0]   r2_etanum;
    logic [IW-1:0] r2_ei;
    logic [IW-1:0] r2_et;

    assign w_zc2  = r1_zc * r1_zc;
    assign w_xabs = r1_it.x[DW-1] ? (~r1_it.x + 16'd1) : r1_it.x;
    assign w_yabs = r1_it.y[DW-1] ? (~r1_it.y + 16'd1) : r1_it.y;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_it     <= r1_it;
            r2_s      <= 29'(ONE_SQ - w_zc2);
            r2_ei2    <= r1_ei * r1_ei;
            r2_et2    <= r1_et * r1_et;
            r2_mx     <= w_xabs * r1_ei;
            r2_my     <= w_yabs * r1_ei;
            r2_a0     <= r1_ei * r1_zc;
            r2_p0     <= r1_et * r1_zc;
            r2_etanum <= {1'b0, r1_ei, 12'd0} + {14'd0, r1_et[IW-1:1]};
            r2_ei     <= r1_ei;
            r2_et     <= r1_et;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // eta^2 sin^2 numerator and the rounded lateral numerators.
    t_item         r3_it;
    logic [56:0]   r3_lhs;
    logic [27:0]   r3_et2;
    logic [QN-1:0] r3_xnum;
    logic [QN-1:0] r3_ynum;
    logic [26:0]   r3_etanum;
    logic [28:0]   r3_a0;
    logic [28:0]   r3_p0;
    logic [IW-1:0] r3_ei;
    logic [IW-1:0] r3_et;
    logic          r3_eq;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_it     <= r2_it;
            r3_lhs    <= r2_s * r2_ei2;
            r3_et2    <= r2_et2;
            r3_xnum   <= {1'b0, r2_mx} + {18'd0, r2_et[IW-1:1]};
            r3_ynum   <= {1'b0, r2_my} + {18'd0, r2_et[IW-1:1]};
            r3_etanum <= r2_etanum;
            r3_a0     <= r2_a0;
            r3_p0     <= r2_p0;
            r3_ei     <= r2_ei;
            r3_et     <= r2_et;
            r3_eq     <= (r2_ei == r2_et);
        end
    end

    // ------------------------------------------------- first division group
    // sin^2(thetaT), eta and the two transmitted lateral magnitudes.
    logic [QN-1:0] w_q_s2t;
    logic [QN-1:0] w_q_eta;
    logic [QN-1:0] w_q_x;
    logic [QN-1:0] w_q_y;
    t_sa           r_sa [QN];

    dbs_div #(.NW(59), .DW(28), .QW(QN)) u_div_s2t (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({r3_lhs, 2'b00}),
        .i_den (r3_et2),
        .o_quo (w_q_s2t)
    );

    dbs_div #(.NW(QN), .DW(IW), .QW(QN)) u_div_eta (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({4'd0, r3_etanum}),
        .i_den (r3_et),
        .o_quo (w_q_eta)
    );

    dbs_div #(.NW(QN), .DW(IW), .QW(QN)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r3_xnum),
        .i_den (r3_et),
        .o_quo (w_q_x)
    );

    dbs_div #(.NW(QN), .DW(IW), .QW(QN)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r3_ynum),
        .i_den (r3_et),
        .o_quo (w_q_y)
    );

    // Total internal reflection: sin2I * etaI^2 >= etaT^2, both sides in Q52.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sa[0].it  <= r3_it;
            r_sa[0].tir <= (r3_lhs >= {1'b0, r3_et2, 28'd0});
            r_sa[0].eq  <= r3_eq;
            r_sa[0].a0  <= r3_a0;
            r_sa[0].p0  <= r3_p0;
            r_sa[0].ei  <= r3_ei;
            r_sa[0].et  <= r3_et;
            for (int k = 1; k < QN; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // ---------------------------------------------------------- result prep
    // Saturate eta, form the reflected and transmitted lateral components and
    // the square root operand (1 - sin2T) in Q60.
    t_sa           w_sa;
    logic [QN-1:0] w_s2t_c;
    t_sb           r_b;
    logic [61:0]   r_b_rad;

    assign w_sa    = r_sa[QN-1];
    assign w_s2t_c = (w_q_s2t > ONE_FX) ? ONE_FX : w_q_s2t;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b.res.tir <= w_sa.tir;
            r_b.res.eq  <= w_sa.eq;
            r_b.res.ent <= w_sa.it.ent;
            r_b.res.u   <= w_sa.it.u;
            r_b.res.rx  <= f_neg_sat(w_sa.it.x);
            r_b.res.ry  <= f_neg_sat(w_sa.it.y);
            r_b.res.rz  <= w_sa.it.z;
            r_b.res.tx  <= f_tx(w_sa.it.x[DW-1], w_q_x);
            r_b.res.ty  <= f_tx(w_sa.it.y[DW-1], w_q_y);
            r_b.res.tz  <= '0;
            r_b.res.eta <= (w_q_eta > {17'd0, dbs_pkg::ETA_MAX}) ?
                           dbs_pkg::ETA_MAX : w_q_eta[IW-1:0];
            r_b.a0      <= w_sa.a0;
            r_b.p0      <= w_sa.p0;
            r_b.ei      <= w_sa.ei;
            r_b.et      <= w_sa.et;
            r_b_rad     <= {1'b0, ONE_FX - w_s2t_c, 30'd0};
        end
    end

    // ----------------------------------------------------------- square root
    // One root bit per stage, two radicand bits shifted in each step.
    logic [32:0]   r_sq_rem  [QN];
    logic [QN-1:0] r_sq_root [QN];
    logic [61:0]   r_sq_w    [QN];
    logic [32:0]   n_sq_rem  [QN];
    logic [QN-1:0] n_sq_root [QN];
    logic [61:0]   n_sq_w    [QN];
    t_sb           r_sbd     [QN];

    always_comb begin
        logic [32:0]   rem;
        logic [QN-1:0] root;
        logic [61:0]   w;
        logic [34:0]   rs;
        logic [35:0]   d;
        for (int k = 0; k < QN; k++) begin
            if (k == 0) begin
                rem  = '0;
                root = '0;
                w    = r_b_rad;
            end else begin
                rem  = r_sq_rem[k-1];
                root = r_sq_root[k-1];
                w    = r_sq_w[k-1];
            end
            rs           = {rem[32:0], w[61:60]};
            d            = {1'b0, rs} - {3'd0, root, 2'b01};
            n_sq_rem[k]  = d[35] ? rs[32:0] : d[32:0];
            n_sq_root[k] = {root[QN-2:0], ~d[35]};
            n_sq_w[k]    = {w[59:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < QN; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_w[k]    <= n_sq_w[k];
            end
            r_sbd[0] <= r_b;
            for (int k = 1; k < QN; k++) begin
                r_sbd[k] <= r_sbd[k-1];
            end
        end
    end

    // --------------------------------------------------- Fresnel products
    logic [QN-1:0] w_ct;
    t_sb           w_sb;
    logic [44:0]   w_bm;
    logic [44:0]   w_qm;
    logic [31:0]   w_zr;
    t_sc           r_c1;

    assign w_ct = r_sq_root[QN-1];
    assign w_sb = r_sbd[QN-1];
    assign w_bm = w_sb.et * w_ct;
    assign w_qm = w_sb.ei * w_ct;
    assign w_zr = {1'b0, w_ct} + 32'h0000_8000;     // round cosT half up to Q14

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1.res <= w_sb.res;
            r_c1.a   <= {w_sb.a0, 2'b00};
            r_c1.p   <= {w_sb.p0, 2'b00};
            r_c1.b   <= w_bm[44:14];
            r_c1.q   <= w_qm[44:14];
            r_c1.zq  <= w_zr[31:16];
        end
    end

    // ------------------------------------------ differences and sums, sign
    t_res        r_c2;
    t_res        w_c1_res;
    logic [29:0] r_c2_dfs;
    logic [29:0] r_c2_dfp;
    logic [QN-1:0] r_c2_dns;
    logic [QN-1:0] r_c2_dnp;
    logic [QN-1:0] w_dfs;
    logic [QN-1:0] w_dfp;

    assign w_dfs = (r_c1.a > r_c1.b) ? (r_c1.a - r_c1.b) : (r_c1.b - r_c1.a);
    assign w_dfp = (r_c1.p > r_c1.q) ? (r_c1.p - r_c1.q) : (r_c1.q - r_c1.p);

    always_comb begin
        w_c1_res    = r_c1.res;
        // leaving the surface keeps z positive, entering turns it down
        w_c1_res.tz = r_c1.res.ent ? (~r_c1.zq + 16'd1) : r_c1.zq;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c2     <= w_c1_res;
            r_c2_dfs <= w_dfs[29:0];
            r_c2_dfp <= w_dfp[29:0];
            r_c2_dns <= r_c1.a + r_c1.b;
            r_c2_dnp <= r_c1.p + r_c1.q;
        end
    end

    // ------------------------------------------------- Fresnel ratios
    logic [QN-1:0] w_q_rs;
    logic [QN-1:0] w_q_rp;
    t_res          r_sdd [QN];

    dbs_div #(.NW(60), .DW(QN), .QW(QN)) u_div_rs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({r_c2_dfs, 30'd0}),
        .i_den (r_c2_dns),
        .o_quo (w_q_rs)
    );

    dbs_div #(.NW(60), .DW(QN), .QW(QN)) u_div_rp (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({r_c2_dfp, 30'd0}),
        .i_den (r_c2_dnp),
        .o_quo (w_q_rp)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sdd[0] <= r_c2;
            for (int k = 1; k < QN; k++) begin
                r_sdd[k] <= r_sdd[k-1];
            end
        end
    end

    // --------------------------------------------------- squared ratios
    // A zero denominator divides to all ones and clamps to 1.0.
    logic [QN-1:0]   w_rs_c;
    logic [QN-1:0]   w_rp_c;
    logic [2*QN-1:0] w_rs2;
    logic [2*QN-1:0] w_rp2;
    t_res            r_e1;
    logic [QN-1:0]   r_e1_rs;
    logic [QN-1:0]   r_e1_rp;

    assign w_rs_c = (w_q_rs > ONE_FX) ? ONE_FX : w_q_rs;
    assign w_rp_c = (w_q_rp > ONE_FX) ? ONE_FX : w_q_rp;
    assign w_rs2  = w_rs_c * w_rs_c;
    assign w_rp2  = w_rp_c * w_rp_c;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1    <= r_sdd[QN-1];
            r_e1_rs <= w_rs2[60:30];
            r_e1_rp <= w_rp2[60:30];
        end
    end

    // ------------------------------------------------------- decision, output
    logic [31:0]   w_fsum;
    logic [QN-1:0] w_f;
    logic          w_refl;

    assign w_fsum = {1'b0, r_e1_rs} + {1'b0, r_e1_rp};
    assign w_f    = r_e1.eq ? '0 : w_fsum[31:1];
    assign w_refl = ({1'b0, r_e1.u, 14'd0} < w_f);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_eta_ratio <= r_e1.eta;
            if (r_e1.tir || w_refl) begin
                o_out_dir_x  <= r_e1.rx;
                o_out_dir_y  <= r_e1.ry;
                o_out_dir_z  <= r_e1.rz;
                o_event_kind <= r_e1.tir ? dbs_pkg::EV_TIR : dbs_pkg::EV_REFL;
            end else begin
                o_out_dir_x  <= r_e1.tx;
                o_out_dir_y  <= r_e1.ty;
                o_out_dir_z  <= r_e1.tz;
                o_event_kind <= dbs_pkg::EV_TRAN;
            end
        end
    end

endmodule
`default_nettype wire
